@@ rtl/core/slist_pkg.sv @@
// ----------------------------------------------------------------------------
// slist_pkg
// Shared types and constants of the sorted list engine: default sizes,
// command and status codes, and the input and result word layouts.
// ----------------------------------------------------------------------------
package slist_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned VALUE_BITS_DEF = 32;

  // Fixed widths of the word fields
  localparam int unsigned CMD_W   = 4;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned IDX_W   = 7;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND         = 4'd0,
    CMD_APPEND_NO_LAST = 4'd1,
    CMD_SORTED_INSERT  = 4'd2,
    CMD_INSERT_ABSENT  = 4'd3,
    CMD_SEARCH         = 4'd4,
    CMD_INSERT_AT      = 4'd5,
    CMD_REMOVE_AT      = 4'd6,
    CMD_CLEAR          = 4'd7,
    CMD_READ_AT        = 4'd8
  } slist_cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_DUP  = 2'd3
  } slist_status_e;

  // Input word
  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
  } slist_in_t;

  // Result word
  typedef struct packed {
    logic                      found;
    logic [IDX_W-1:0]          index;
    logic signed [VALUE_W-1:0] element_value;
    logic [IDX_W-1:0]          element_count;
    slist_status_e             status;
  } slist_out_t;

endpackage

@@ rtl/core/sorted_list_engine.sv @@
// ----------------------------------------------------------------------------
// sorted_list_engine
// Bounded list of signed integers with append, sorted and positional insert,
// binary search, removal, clear and indexed read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one command
//   word; the block stalls the input until that command is finished and its
//   result has moved into the output register. Output channel (out_valid_o /
//   out_stall_i / out_word_o) delivers exactly one result word per command.
//   Steps from acceptance to result valid:
//     append, clear, bad position, full list : decided on acceptance
//     read_at, append_if_not_last            : one memory read (none if empty)
//     search                                 : ends then bisection; none if empty
//     inserts                                : upward shift (+ search)
//     remove_at                              : downward shift
//   One list memory port pair (one read, one write per cycle) serves
//   these steps: a shift moves one entry per cycle, a search probe is one read.
//   Reset empties the list; the memory contents are not cleared. While the
//   receiver stalls, the result word holds and the next command is accepted
//   as soon as the sequencer is free; it finishes once the word is taken.
// ----------------------------------------------------------------------------
module sorted_list_engine
  import slist_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  slist_in_t  in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output slist_out_t out_word_o
);

  logic       res_valid, res_ready, load;
  slist_out_t res;
  logic       out_valid_q, out_valid_d;
  slist_out_t out_q;

  slist_ctrl #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Take a new result when the register is empty or drains this cycle
  assign res_ready = !out_valid_q || !out_stall_i;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

@@ rtl/core/slist_ram.sv @@
// ----------------------------------------------------------------------------
// slist_ram
// Generic simple dual port RAM: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module slist_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, hold the last data when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/slist_ctrl.sv @@
// ----------------------------------------------------------------------------
// slist_ctrl
// Command sequencer of the sorted list engine. Owns the list memory and the
// entry count, runs the binary search, the upward shift for inserts and the
// downward shift for removals one memory access per cycle.
// ----------------------------------------------------------------------------
module slist_ctrl
  import slist_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  slist_in_t  in_word_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output slist_out_t res_o
);

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LAST     = 3'd1;
  localparam logic [2:0] ST_OPEN     = 3'd2;
  localparam logic [2:0] ST_SHIFT_UP = 3'd3;
  localparam logic [2:0] ST_PUT      = 3'd4;
  localparam logic [2:0] ST_SHIFT_DN = 3'd5;
  localparam logic [2:0] ST_SEARCH   = 3'd6;
  localparam logic [2:0] ST_RESP     = 3'd7;

  // Search phases
  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_MID = 2'd2;
  localparam logic [1:0] PH_RD  = 2'd3;

  logic [2:0]             state_q, state_d;
  logic [1:0]             phase_q, phase_d;
  logic [CMD_W-1:0]       cmd_q, cmd_d;
  logic [VALUE_BITS-1:0]  x_q, x_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]       lim_q, lim_d;
  logic [ADDR_W-1:0]      lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  slist_out_t             res_q, res_d;

  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [VALUE_BITS-1:0]  mem_wdata, mem_rdata;

  logic [VALUE_BITS-1:0]  x_in;
  logic                   full;
  logic [CMP_W-1:0]       pos_c, count_c;
  logic [CNT_W-1:0]       count_m1, wr_m1;
  logic                   x_lt, x_eq, x_gt, cont;
  logic                   s_hit, s_miss;
  logic [CNT_W-1:0]       s_addr;
  logic [ADDR_W-1:0]      n_lo, n_hi;
  logic [ADDR_W:0]        mid_sum, lo_p1;

  slist_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Fit the incoming value to the stored width
  assign x_in     = VALUE_BITS'(in_word_i.value);
  assign full     = (count_q == CNT_W'(CAPACITY));
  assign pos_c    = CMP_W'(in_word_i.position);
  assign count_c  = CMP_W'(count_q);
  assign count_m1 = count_q - 1'b1;
  assign wr_m1    = wr_ptr_q - 1'b1;

  // Compare the memory word against the held value
  assign x_lt = $signed(x_q) < $signed(mem_rdata);
  assign x_eq = (x_q == mem_rdata);
  assign x_gt = $signed(x_q) > $signed(mem_rdata);

  // Sorted insert moves entries above the value, other inserts move all
  assign cont = (cmd_q == CMD_SORTED_INSERT) ? x_lt : 1'b1;

  // Next bisection bounds
  assign n_lo    = (!x_eq && !x_lt) ? mid_q : lo_q;
  assign n_hi    = x_lt ? mid_q : hi_q;
  assign mid_sum = ({1'b0, n_lo} + {1'b0, n_hi}) >> 1;
  assign lo_p1   = {1'b0, n_lo} + 1'b1;

  // Search outcome of this probe
  always_comb begin
    s_hit  = 1'b0;
    s_miss = 1'b0;
    s_addr = '0;
    case (phase_q)
      PH_LO: begin
        if (x_lt) begin
          s_miss = 1'b1;
        end else if (x_eq) begin
          s_hit = 1'b1;
        end
      end
      PH_HI: begin
        if (x_gt) begin
          s_miss = 1'b1;
          s_addr = count_q;
        end else if (x_eq) begin
          s_hit  = 1'b1;
          s_addr = count_m1;
        end else if (count_m1 <= CNT_W'(1)) begin
          s_miss = 1'b1;
          s_addr = count_m1;
        end
      end
      PH_MID: begin
        if (x_eq) begin
          s_hit  = 1'b1;
          s_addr = CNT_W'(mid_q);
        end else if (!(lo_p1 < {1'b0, n_hi})) begin
          s_miss = 1'b1;
          s_addr = CNT_W'(n_hi);
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cmd_d     = cmd_q;
    x_d       = x_q;
    count_d   = count_q;
    wr_ptr_d  = wr_ptr_q;
    lim_d     = lim_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = wr_ptr_q[ADDR_W-1:0];
    mem_wdata = x_q;
    mem_re    = 1'b0;
    mem_raddr = wr_m1[ADDR_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = in_word_i.command;
          x_d      = x_in;
          res_d    = '0;
          wr_ptr_d = count_q;
          state_d  = ST_RESP;
          case (in_word_i.command)
            CMD_APPEND: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = count_q[ADDR_W-1:0];
                mem_wdata   = x_in;
                count_d     = count_q + 1'b1;
                res_d.index = IDX_W'(count_q);
              end
            end
            CMD_APPEND_NO_LAST: begin
              if (count_q == '0) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = x_in;
                count_d   = count_q + 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = count_m1[ADDR_W-1:0];
                state_d   = ST_LAST;
              end
            end
            CMD_SORTED_INSERT: begin
              if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                lim_d   = '0;
                state_d = ST_OPEN;
              end
            end
            CMD_INSERT_ABSENT, CMD_SEARCH: begin
              if (count_q == '0) begin
                if (in_word_i.command == CMD_INSERT_ABSENT) begin
                  lim_d   = '0;
                  state_d = ST_OPEN;
                end
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                phase_d   = PH_LO;
                state_d   = ST_SEARCH;
              end
            end
            CMD_INSERT_AT: begin
              if (pos_c > count_c) begin
                res_d.status = STAT_RANGE;
              end else if (full) begin
                res_d.status = STAT_FULL;
              end else begin
                lim_d   = CNT_W'(in_word_i.position);
                state_d = ST_OPEN;
              end
            end
            CMD_REMOVE_AT: begin
              if (pos_c >= count_c) begin
                res_d.status = STAT_RANGE;
              end else begin
                res_d.index = IDX_W'(in_word_i.position);
                if (pos_c + 1'b1 < count_c) begin
                  wr_ptr_d  = CNT_W'(in_word_i.position) + 1'b1;
                  mem_re    = 1'b1;
                  mem_raddr = ADDR_W'(wr_ptr_d);
                  state_d   = ST_SHIFT_DN;
                end else begin
                  count_d = count_m1;
                end
              end
            end
            CMD_CLEAR: begin
              count_d = '0;
            end
            CMD_READ_AT: begin
              if (pos_c >= count_c) begin
                res_d.status = STAT_RANGE;
              end else begin
                res_d.index = IDX_W'(in_word_i.position);
                mem_re      = 1'b1;
                mem_raddr   = ADDR_W'(in_word_i.position);
                phase_d     = PH_RD;
                state_d     = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // Compare against the last entry, append when it differs and the list is not full
      ST_LAST: begin
        state_d = ST_RESP;
        if (x_eq) begin
          res_d.status = STAT_DUP;
          res_d.index  = IDX_W'(count_m1);
        end else if (full) begin
          res_d.status = STAT_FULL;
        end else begin
          mem_we      = 1'b1;
          mem_waddr   = count_q[ADDR_W-1:0];
          count_d     = count_q + 1'b1;
          res_d.index = IDX_W'(count_q);
        end
      end

      // Start the upward shift, or drop the value straight in
      ST_OPEN: begin
        if (wr_ptr_q == lim_q) begin
          mem_we      = 1'b1;
          count_d     = count_q + 1'b1;
          res_d.index = IDX_W'(wr_ptr_q);
          state_d     = ST_RESP;
        end else begin
          mem_re  = 1'b1;
          state_d = ST_SHIFT_UP;
        end
      end

      // Move one entry up per cycle, prefetch the next one below; place the value where the shift stops early
      ST_SHIFT_UP: begin
        mem_we = 1'b1;
        if (cont) begin
          mem_wdata = mem_rdata;
          wr_ptr_d  = wr_m1;
          if (wr_m1 == lim_q) begin
            state_d = ST_PUT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = ADDR_W'(wr_ptr_q - CNT_W'(2));
          end
        end else begin
          count_d     = count_q + 1'b1;
          res_d.index = IDX_W'(wr_ptr_q);
          state_d     = ST_RESP;
        end
      end

      // Write the new value into the opened slot
      ST_PUT: begin
        mem_we      = 1'b1;
        count_d     = count_q + 1'b1;
        res_d.index = IDX_W'(wr_ptr_q);
        state_d     = ST_RESP;
      end

      // Move one entry down per cycle, prefetch the next one above
      ST_SHIFT_DN: begin
        mem_we    = 1'b1;
        mem_waddr = wr_m1[ADDR_W-1:0];
        mem_wdata = mem_rdata;
        if (wr_ptr_q + 1'b1 < count_q) begin
          wr_ptr_d  = wr_ptr_q + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = ADDR_W'(wr_ptr_d);
        end else begin
          count_d = count_m1;
          state_d = ST_RESP;
        end
      end

      // Binary search probes, and the read of read_at
      ST_SEARCH: begin
        if (phase_q == PH_RD) begin
          res_d.element_value = VALUE_W'($signed(mem_rdata));
          state_d             = ST_RESP;
        end else if (s_hit) begin
          res_d.found  = 1'b1;
          res_d.index  = IDX_W'(s_addr);
          res_d.status = (cmd_q == CMD_INSERT_ABSENT) ? STAT_DUP : STAT_DONE;
          state_d      = ST_RESP;
        end else if (s_miss) begin
          state_d = ST_RESP;
          if (cmd_q == CMD_SEARCH) begin
            res_d.index = IDX_W'(s_addr);
          end else if (full) begin
            res_d.status = STAT_FULL;
          end else begin
            lim_d    = s_addr;
            wr_ptr_d = count_q;
            state_d  = ST_OPEN;
          end
        end else begin
          mem_re = 1'b1;
          if (phase_q == PH_LO) begin
            mem_raddr = count_m1[ADDR_W-1:0];
            phase_d   = PH_HI;
          end else if (phase_q == PH_HI) begin
            lo_d      = '0;
            hi_d      = count_m1[ADDR_W-1:0];
            mid_d     = ADDR_W'(count_m1 >> 1);
            mem_raddr = mid_d;
            phase_d   = PH_MID;
          end else begin
            lo_d      = n_lo;
            hi_d      = n_hi;
            mid_d     = mid_sum[ADDR_W-1:0];
            mem_raddr = mid_d;
          end
        end
      end

      // Hand the result word over
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    phase_q  <= phase_d;
    cmd_q    <= cmd_d;
    x_q      <= x_d;
    wr_ptr_q <= wr_ptr_d;
    lim_q    <= lim_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    res_q    <= res_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_RESP);

  // Report the count held after the command
  always_comb begin
    res_o               = res_q;
    res_o.element_count = IDX_W'(count_q);
  end

endmodule

@@ rtl/core/slist_checker.sv @@
// ----------------------------------------------------------------------------
// slist_checker
// Port level checks of the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
module slist_checker
  import slist_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input slist_out_t out_word_o
);

  // Stall the input right after a command word is taken
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after a command word was taken");

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // A full list keeps exactly CAPACITY entries and reports index zero
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == STAT_FULL |->
      out_word_o.element_count == IDX_W'(CAPACITY) && out_word_o.index == '0)
    else $error("full status with wrong count or index");

  // A hit is never reported with full or range status
  a_found_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.found |->
      out_word_o.status == STAT_DONE || out_word_o.status == STAT_DUP)
    else $error("found flag with bad status");

  // Bad positions leave index and value at zero
  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == STAT_RANGE |->
      out_word_o.index == '0 && out_word_o.element_value == '0 && !out_word_o.found)
    else $error("range status with nonzero fields");

endmodule

bind sorted_list_engine slist_checker #(
  .CAPACITY (CAPACITY)
) u_slist_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
